FILE: hdl/pmwt_pkg.sv
// Shared types and constants for the per-CPU minimum watermark tracker.
// No dependencies; the top level, front end and back end import this package.
package pmwt_pkg;

  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int TS_W  = 64;

  localparam logic [CNT_W-1:0] CPU_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [IDX_W-1:0] cpu_index;
    logic [TS_W-1:0]  ts;
    logic             in_range;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [TS_W-1:0] ns;
    logic [TS_W-1:0] vt;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

FILE: hdl/pmwt_in_if.sv
// Input channel: one CPU sample per word, valid/ready handshake.
// No dependencies.
interface pmwt_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cpu_index;
  logic [63:0] event_ts;
  logic [63:0] stat_ts;
  logic        last_of_round;

  modport source (output valid, cpu_index, event_ts, stat_ts, last_of_round, input ready);
  modport sink   (input valid, cpu_index, event_ts, stat_ts, last_of_round, output ready);
endinterface

FILE: hdl/pmwt_out_if.sv
// Output channel: one round result per word, valid/ready handshake.
// No dependencies.
interface pmwt_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] global_ns;
  logic [63:0] global_vtime;
  logic [63:0] current_vtime;
  logic        any_cpu_advanced;
  logic        watermark_update;
  logic        vtime_advanced;
  logic        vtime_ticked;

  modport source (output valid, global_ns, global_vtime, current_vtime, any_cpu_advanced,
                  watermark_update, vtime_advanced, vtime_ticked, input ready);
  modport sink   (input valid, global_ns, global_vtime, current_vtime, any_cpu_advanced,
                  watermark_update, vtime_advanced, vtime_ticked, output ready);
endinterface

FILE: hdl/per_cpu_min_watermark_tracker_top.sv
// Per-CPU minimum watermark tracker, top level: front end, word queue, back end, CPU RAM.
// Depends on pmwt_pkg, pmwt_in_if, pmwt_out_if, pmwt_ram, pmwt_front, pmwt_back.
// In the back end a sample that does not end a round takes a RAM read, then a compare/write.
// A round-ending sample adds a walk with one RAM read per active CPU, then a tail and a finish step.
// Results stay registered. Reset clears all control; a clear pass then zeroes the RAM with ready low.
module per_cpu_min_watermark_tracker_top #(
  parameter int MAX_CPUS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pmwt_pkg::CNT_W-1:0] cfg_wdata_i,
  pmwt_in_if.sink                    in_i,
  pmwt_out_if.source                 out_o
);
  import pmwt_pkg::*;

  localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

  back_status_t  status;
  logic          pop;
  logic          head_valid;
  item_t         head;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  pmwt_front #(.MAX_CPUS(MAX_CPUS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .status_i     (status),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pmwt_back #(.MAX_CPUS(MAX_CPUS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .status_o     (status),
    .out_o        (out_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  pmwt_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_CPUS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: hdl/pmwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmwt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/pmwt_front.sv
// Front end: accepts samples, picks the newer timestamp, flags range, queues words.
// Depends on pmwt_pkg and pmwt_in_if.
module pmwt_front #(
  parameter int MAX_CPUS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pmwt_in_if.sink               in_i,
  input  pmwt_pkg::back_status_t status_i,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output pmwt_pkg::item_t       head_o
);
  import pmwt_pkg::*;

  localparam int NW = ($clog2(MAX_CPUS + 1) > CNT_W) ? $clog2(MAX_CPUS + 1) : CNT_W;

  item_t       item;
  item_t       q_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  always_comb begin
    item.cpu_index = in_i.cpu_index;
    item.ts        = (in_i.stat_ts > in_i.event_ts) ? in_i.stat_ts : in_i.event_ts;
    item.in_range  = {{(NW-IDX_W){1'b0}}, in_i.cpu_index} < NW'(MAX_CPUS);
    item.last      = in_i.last_of_round;
  end

  assign in_i.ready   = (cnt_q != 2'd2) && !status_i.clearing;
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = q_q[rptr_q];

  always_comb begin
    wptr_d = push  ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= item;
    end
  end

endmodule

FILE: hdl/pmwt_back.sv
// Back end: per-CPU update, end-of-round minimum walk, global marks, result register.
// Depends on pmwt_pkg and pmwt_out_if; drives the per-CPU RAM held in the top level.
module pmwt_back #(
  parameter int MAX_CPUS = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [pmwt_pkg::CNT_W-1:0]               cfg_wdata_i,
  input  logic                                     head_valid_i,
  input  pmwt_pkg::item_t                          head_i,
  output logic                                     pop_o,
  output pmwt_pkg::back_status_t                   status_o,
  pmwt_out_if.source                               out_o,
  output logic                                     ram_we_o,
  output logic [((MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1)-1:0] ram_waddr_o,
  output pmwt_pkg::entry_t                         ram_wdata_o,
  output logic [((MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1)-1:0] ram_raddr_o,
  input  pmwt_pkg::entry_t                         ram_rdata_i
);
  import pmwt_pkg::*;

  localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int NW = ($clog2(MAX_CPUS + 1) > CNT_W) ? $clog2(MAX_CPUS + 1) : CNT_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [NW-1:0]    walk_cnt_q, walk_cnt_d;
  logic             rd_pend_q, rd_pend_d;
  logic [TS_W-1:0]  min_ns_q, min_ns_d;
  logic [TS_W-1:0]  min_vt_q, min_vt_d;
  logic [TS_W-1:0]  g_ns_q, g_ns_d;
  logic [TS_W-1:0]  g_vt_q, g_vt_d;
  logic [TS_W-1:0]  vcnt_q, vcnt_d;
  logic             changed_q, changed_d;
  logic [CNT_W-1:0] cpu_count_q;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             out_any_q, out_wm_q, out_vadv_q, out_tick_q;
  logic [NW-1:0]    cnt_ext;
  logic [NW-1:0]    n_last;
  logic             wm, vadv, tick;

  assign cnt_ext = NW'(cpu_count_q);

  always_comb begin
    if (cnt_ext == '0) begin
      n_last = '0;
    end else if (cnt_ext > NW'(MAX_CPUS)) begin
      n_last = NW'(MAX_CPUS - 1);
    end else begin
      n_last = cnt_ext - NW'(1);
    end
  end

  assign wm       = min_ns_q > g_ns_q;
  assign vadv     = min_vt_q > g_vt_q;
  assign tick     = !wm && !changed_q;
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    walk_cnt_d  = walk_cnt_q;
    rd_pend_d   = 1'b0;
    min_ns_d    = min_ns_q;
    min_vt_d    = min_vt_q;
    g_ns_d      = g_ns_q;
    g_vt_d      = g_vt_q;
    vcnt_d      = vcnt_q;
    changed_d   = changed_q;
    pop_o       = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(head_i.cpu_index);
    ram_wdata_o = '{ns: head_i.ts, vt: vcnt_q};
    ram_raddr_o = AW'(head_i.cpu_index);
    out_valid_d = (out_valid_q && out_o.ready) ? 1'b0 : out_valid_q;

    // fold walk data in the cycle after its read
    if (rd_pend_q) begin
      if (ram_rdata_i.ns < min_ns_q) min_ns_d = ram_rdata_i.ns;
      if (ram_rdata_i.vt < min_vt_q) min_vt_d = ram_rdata_i.vt;
    end

    case (state_q)
      S_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_cnt_q;
        ram_wdata_o = '0;
        clr_cnt_d   = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(MAX_CPUS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (head_valid_i) state_d = S_UPD;
      end
      S_UPD: begin
        pop_o = 1'b1;
        if (head_i.in_range && (head_i.ts > ram_rdata_i.ns)) begin
          ram_we_o  = 1'b1;
          changed_d = 1'b1;
        end
        if (head_i.last) begin
          min_ns_d   = '1;
          min_vt_d   = '1;
          walk_cnt_d = '0;
          state_d    = S_WALK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        ram_raddr_o = walk_cnt_q[AW-1:0];
        rd_pend_d   = 1'b1;
        walk_cnt_d  = walk_cnt_q + NW'(1);
        if (walk_cnt_q == n_last) state_d = S_TAIL;
      end
      S_TAIL: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          if (wm)   g_ns_d = min_ns_q;
          if (vadv) g_vt_d = min_vt_q;
          if (tick) vcnt_d = vcnt_q + 64'd1;
          changed_d   = 1'b0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign status_o.clearing = state_q == S_CLR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      walk_cnt_q  <= '0;
      rd_pend_q   <= 1'b0;
      g_ns_q      <= '0;
      g_vt_q      <= '0;
      vcnt_q      <= '0;
      changed_q   <= 1'b0;
      cpu_count_q <= CPU_COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      walk_cnt_q  <= walk_cnt_d;
      rd_pend_q   <= rd_pend_d;
      g_ns_q      <= g_ns_d;
      g_vt_q      <= g_vt_d;
      vcnt_q      <= vcnt_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cpu_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    min_ns_q <= min_ns_d;
    min_vt_q <= min_vt_d;
    if (out_load) begin
      out_any_q  <= changed_q;
      out_wm_q   <= wm;
      out_vadv_q <= vadv;
      out_tick_q <= tick;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.global_ns        = g_ns_q;
  assign out_o.global_vtime     = g_vt_q;
  assign out_o.current_vtime    = vcnt_q;
  assign out_o.any_cpu_advanced = out_any_q;
  assign out_o.watermark_update = out_wm_q;
  assign out_o.vtime_advanced   = out_vadv_q;
  assign out_o.vtime_ticked     = out_tick_q;

endmodule

FILE: hdl/pmwt_checker.sv
// Port-level checks for the tracker top level, and the bind that attaches them.
// Depends on per_cpu_min_watermark_tracker_top.
module pmwt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] global_ns_i,
  input logic        any_i,
  input logic        wm_i,
  input logic        tick_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(global_ns_i))
    else $error("stalled result word changed");

  a_wm_no_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && wm_i |-> !tick_i)
    else $error("tick together with watermark update");

  a_tick_idle_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tick_i |-> !any_i)
    else $error("tick in a round where a CPU advanced");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i && !out_valid_i)
    else $error("input open before RAM clear");

endmodule

bind per_cpu_min_watermark_tracker_top pmwt_checker u_pmwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .global_ns_i (out_o.global_ns),
  .any_i       (out_o.any_cpu_advanced),
  .wm_i        (out_o.watermark_update),
  .tick_i      (out_o.vtime_ticked)
);
